// ===== src/adc_tbs_pkg.sv =====
`default_nettype none
package adc_tbs_pkg;

    localparam int MAX_CHANNELS  = 32;
    localparam int MAX_STEPS     = 16;
    localparam int BUFFER_COUNT  = 3;
    localparam logic [15:0] UNKNOWN_LEVEL = 16'hffff;

    localparam int LEVEL_DEPTH = BUFFER_COUNT * MAX_CHANNELS;
    localparam int ADDR_W      = $clog2(LEVEL_DEPTH);
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        REG_CHANNEL_COUNT  = 2'd0,
        REG_STEP_COUNT     = 2'd1,
        REG_FINISH_TIMEOUT = 2'd2,
        REG_LEVEL_MAX      = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        CMD_TICK           = 3'd0,
        CMD_SEQ_ACTIVATE   = 3'd1,
        CMD_SEQ_DEACTIVATE = 3'd2,
        CMD_STEP_START     = 3'd3,
        CMD_STEP_FINISH    = 3'd4,
        CMD_READ           = 3'd5,
        CMD_WRITE_SAMPLE   = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        ACT_NONE        = 3'd0,
        ACT_CONV_INIT   = 3'd1,
        ACT_START_STEP  = 3'd2,
        ACT_FINISH_STEP = 3'd3,
        ACT_READ_REPLY  = 3'd4
    } t_action;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        init_flag;
        logic [5:0]  channel;
        logic [15:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  step_index;
        logic [1:0]  buffer_index;
        logic [15:0] level;
        logic        level_valid;
        logic        seq_active;
    } t_out_item;

    typedef struct packed {
        logic [5:0]  channel_count;
        logic [4:0]  step_count;
        logic [15:0] finish_timeout;
        logic [15:0] level_max;
    } t_cfg;

endpackage
`default_nettype wire

// ===== src/adc_triple_buffer_sequencer.sv =====
// Path: an accepted transaction is registered in the front stage, then written into the
// four-entry result queue, which offers it at the output and decouples the output side.
// Throughput: one transaction per cycle while the queue and front stage have room, set by
// the combinational control update and the registered level-store read.
// Reset: synchronous, active low; loads configuration defaults, clears sequence state, buffer
// roles and level-store entry valid bits, so unwritten entries read as unknown at once.
`default_nettype none
module adc_triple_buffer_sequencer import adc_tbs_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_data
);

    t_cfg              r_cfg;
    logic              cfg_we;
    t_reg_idx          reg_idx;
    logic              push;
    t_out_item         push_data;
    logic [QCNT_W-1:0] q_cnt;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_count  <= 6'd32;
            r_cfg.step_count     <= 5'd16;
            r_cfg.finish_timeout <= 16'd0;
            r_cfg.level_max      <= 16'd4095;
        end else if (cfg_we) begin
            unique case (reg_idx)
                REG_CHANNEL_COUNT:  r_cfg.channel_count  <= pwdata[5:0];
                REG_STEP_COUNT:     r_cfg.step_count     <= pwdata[4:0];
                REG_FINISH_TIMEOUT: r_cfg.finish_timeout <= pwdata[15:0];
                REG_LEVEL_MAX:      r_cfg.level_max      <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CHANNEL_COUNT:  prdata = {26'd0, r_cfg.channel_count};
            REG_STEP_COUNT:     prdata = {27'd0, r_cfg.step_count};
            REG_FINISH_TIMEOUT: prdata = {16'd0, r_cfg.finish_timeout};
            REG_LEVEL_MAX:      prdata = {16'd0, r_cfg.level_max};
            default:            prdata = '0;
        endcase
    end

    adc_tbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_q_cnt     (q_cnt),
        .o_push      (push),
        .o_push_data (push_data)
    );

    adc_tbs_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_cnt       (q_cnt)
    );

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_cnt <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> (q_cnt < QCNT_W'(QDEPTH)))
        else $error("transaction accepted with full queue");

    a_start_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (t_action'(o_out_data.action) == ACT_START_STEP))
        |-> o_out_data.seq_active)
        else $error("step started without active sequence");

    a_level_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (t_action'(o_out_data.action) != ACT_READ_REPLY))
        |-> ((o_out_data.level == 16'd0) && !o_out_data.level_valid))
        else $error("level reported outside a read reply");

endmodule
`default_nettype wire

// ===== src/adc_tbs_ram.sv =====
`default_nettype none
module adc_tbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 96
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== src/adc_tbs_front.sv =====
`default_nettype none
module adc_tbs_front import adc_tbs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in_data,
    input  wire logic [QCNT_W-1:0] i_q_cnt,
    output logic                   o_push,
    output t_out_item              o_push_data
);

    typedef struct packed {
        t_out_item item;
        logic      is_read;
        logic      rd_ok;
        logic      stored;
    } t_stage;

    logic              r_seq_on,   n_seq_on;
    logic [4:0]        r_starts,   n_starts;
    logic [4:0]        r_fins,     n_fins;
    logic [15:0]       r_tcount,   n_tcount;
    logic [1:0]        r_act_buf,  n_act_buf;
    logic [2:0]        r_done_buf, n_done_buf;
    logic [2:0]        r_read_buf, n_read_buf;
    logic [LEVEL_DEPTH-1:0] r_lvl_vld, n_lvl_vld;
    logic              r_b_valid;
    t_stage            r_b,        n_b;

    logic              accept;
    logic [QCNT_W:0]   occ;
    logic [4:0]        steps;
    logic [5:0]        eff_ch;
    logic [15:0]       tc_inc;
    logic              tout;
    logic              corrupt;
    logic              ch_ok;
    logic              rd_ok;
    logic              wr_ok;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic              we;
    logic [15:0]       ram_rdata;
    logic [15:0]       lvl;

    assign occ        = {1'b0, i_q_cnt} + {{QCNT_W{1'b0}}, r_b_valid};
    assign o_in_ready = occ < (QCNT_W + 1)'(QDEPTH);
    assign accept     = i_in_valid && o_in_ready;

    assign steps  = (i_cfg.step_count > 5'(MAX_STEPS)) ? 5'(MAX_STEPS) : i_cfg.step_count;
    assign eff_ch = (i_cfg.channel_count > 6'(MAX_CHANNELS)) ?
                    6'(MAX_CHANNELS) : i_cfg.channel_count;
    assign ch_ok  = i_in_data.channel < eff_ch;
    assign rd_ok  = ch_ok && (r_read_buf < 3'(BUFFER_COUNT));
    assign wr_ok  = ch_ok && ({1'b0, r_act_buf} < 3'(BUFFER_COUNT));
    assign raddr  = ADDR_W'(r_read_buf[1:0]) * ADDR_W'(MAX_CHANNELS)
                  + ADDR_W'(i_in_data.channel);
    assign waddr  = ADDR_W'(r_act_buf) * ADDR_W'(MAX_CHANNELS)
                  + ADDR_W'(i_in_data.channel);
    assign we     = accept && (t_cmd'(i_in_data.cmd) == CMD_WRITE_SAMPLE) && wr_ok;

    assign tc_inc  = (r_tcount < 16'hffff) ? (r_tcount + 16'd1) : r_tcount;
    assign tout    = (i_cfg.finish_timeout != 16'd0) && (tc_inc >= i_cfg.finish_timeout);
    assign corrupt = (r_act_buf == 2'd3) || (r_done_buf[1:0] == 2'd3)
                  || (r_read_buf[1:0] == 2'd3) || (r_act_buf == r_done_buf[1:0])
                  || (r_act_buf == r_read_buf[1:0]) || (r_done_buf[1:0] == r_read_buf[1:0]);

    always_comb begin
        n_seq_on   = r_seq_on;
        n_starts   = r_starts;
        n_fins     = r_fins;
        n_tcount   = r_tcount;
        n_act_buf  = r_act_buf;
        n_done_buf = r_done_buf;
        n_read_buf = r_read_buf;
        n_lvl_vld  = r_lvl_vld;
        n_b        = '0;
        n_b.item.action = ACT_NONE;
        if (accept) begin
            unique case (t_cmd'(i_in_data.cmd))
                CMD_TICK: begin
                    n_tcount = tc_inc;
                    if (corrupt || tout) begin
                        n_b.item.action = ACT_CONV_INIT;
                        n_seq_on   = 1'b0;
                        n_starts   = '0;
                        n_fins     = '0;
                        n_act_buf  = 2'd0;
                        n_done_buf = 3'b101;
                        n_read_buf = 3'b110;
                        n_tcount   = '0;
                    end else if (!r_done_buf[2]) begin
                        n_done_buf = {1'b1, r_read_buf[1:0]};
                        n_read_buf = {1'b0, r_done_buf[1:0]};
                        n_tcount   = '0;
                    end
                end
                CMD_SEQ_ACTIVATE: begin
                    if (i_in_data.init_flag || !r_seq_on) begin
                        n_seq_on = 1'b1;
                        n_starts = '0;
                        n_fins   = '0;
                    end
                    if (i_in_data.init_flag) begin
                        n_b.item.action = ACT_CONV_INIT;
                    end
                end
                CMD_SEQ_DEACTIVATE: begin
                    n_b.item.action = r_seq_on ? ACT_CONV_INIT : ACT_NONE;
                    n_seq_on = 1'b0;
                    n_starts = '0;
                    n_fins   = '0;
                end
                CMD_STEP_START: begin
                    if (r_seq_on && (r_act_buf != 2'd3) && (r_starts < steps)
                        && (r_starts == r_fins)) begin
                        n_b.item.action       = ACT_START_STEP;
                        n_b.item.step_index   = r_starts[3:0];
                        n_b.item.buffer_index = r_act_buf;
                        n_starts              = r_starts + 5'd1;
                    end else begin
                        n_b.item.action = r_seq_on ? ACT_CONV_INIT : ACT_NONE;
                        n_seq_on = 1'b0;
                        n_starts = '0;
                        n_fins   = '0;
                    end
                end
                CMD_STEP_FINISH: begin
                    if (r_seq_on && (r_act_buf != 2'd3) && (r_fins < steps)
                        && (r_starts == r_fins + 5'd1)) begin
                        n_b.item.action       = ACT_FINISH_STEP;
                        n_b.item.step_index   = r_fins[3:0];
                        n_b.item.buffer_index = r_act_buf;
                        if (r_fins + 5'd1 >= steps) begin
                            n_act_buf  = r_done_buf[1:0];
                            n_done_buf = {1'b0, r_act_buf};
                            n_seq_on   = 1'b0;
                            n_starts   = '0;
                            n_fins     = '0;
                        end else begin
                            n_fins = r_fins + 5'd1;
                        end
                    end else begin
                        n_b.item.action = r_seq_on ? ACT_CONV_INIT : ACT_NONE;
                        n_seq_on = 1'b0;
                        n_starts = '0;
                        n_fins   = '0;
                    end
                end
                CMD_READ: begin
                    n_b.item.action = ACT_READ_REPLY;
                    n_b.is_read     = 1'b1;
                    n_b.rd_ok       = rd_ok;
                    n_b.stored      = rd_ok && r_lvl_vld[raddr];
                end
                CMD_WRITE_SAMPLE: begin
                    if (wr_ok) begin
                        n_lvl_vld[waddr] = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        n_b.item.seq_active = n_seq_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_on   <= 1'b0;
            r_starts   <= '0;
            r_fins     <= '0;
            r_tcount   <= '0;
            r_act_buf  <= 2'd0;
            r_done_buf <= 3'b101;
            r_read_buf <= 3'b110;
            r_lvl_vld  <= '0;
            r_b_valid  <= 1'b0;
        end else begin
            r_seq_on   <= n_seq_on;
            r_starts   <= n_starts;
            r_fins     <= n_fins;
            r_tcount   <= n_tcount;
            r_act_buf  <= n_act_buf;
            r_done_buf <= n_done_buf;
            r_read_buf <= n_read_buf;
            r_lvl_vld  <= n_lvl_vld;
            r_b_valid  <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b <= n_b;
    end

    adc_tbs_ram #(
        .WIDTH (16),
        .DEPTH (LEVEL_DEPTH)
    ) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_in_data.sample),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    assign lvl = r_b.stored ? ram_rdata : UNKNOWN_LEVEL;

    always_comb begin
        o_push_data = r_b.item;
        if (r_b.is_read) begin
            o_push_data.level       = r_b.rd_ok ? lvl : UNKNOWN_LEVEL;
            o_push_data.level_valid = r_b.rd_ok && (lvl <= i_cfg.level_max);
        end
    end

    assign o_push = r_b_valid;

endmodule
`default_nettype wire

// ===== src/adc_tbs_queue.sv =====
`default_nettype none
module adc_tbs_queue import adc_tbs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire t_out_item         i_push_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_data,
    output logic [QCNT_W-1:0]      o_cnt
);

    t_out_item         r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_cnt,  n_cnt;
    logic              pop;

    assign o_out_valid = r_cnt != '0;
    assign pop         = o_out_valid && i_out_ready;
    assign o_out_data  = r_mem[r_rptr];
    assign o_cnt       = r_cnt;

    always_comb begin
        n_wptr = i_push ? r_wptr + QPTR_W'(1) : r_wptr;
        n_rptr = pop    ? r_rptr + QPTR_W'(1) : r_rptr;
        n_cnt  = r_cnt + QCNT_W'(i_push) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire
